@@ design/swa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swa_pkg
// Operation codes, widths and the pipeline stage records of the signed
// word ALU.
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int WORD_W     = 16;
    localparam int OP_W       = 5;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = WORD_W / DIV_STEPS;

    typedef enum logic [OP_W-1:0] {
        OP_BNOT = 5'd0,
        OP_NOT  = 5'd1,
        OP_NEG  = 5'd2,
        OP_EQ   = 5'd3,
        OP_NE   = 5'd4,
        OP_UGE  = 5'd5,
        OP_GE   = 5'd6,
        OP_UGT  = 5'd7,
        OP_SHR  = 5'd8,
        OP_GT   = 5'd9,
        OP_ULE  = 5'd10,
        OP_LE   = 5'd11,
        OP_ULT  = 5'd12,
        OP_SHL  = 5'd13,
        OP_LT   = 5'd14,
        OP_ADD  = 5'd15,
        OP_SUB  = 5'd16,
        OP_MUL  = 5'd17,
        OP_DIV  = 5'd18,
        OP_MOD  = 5'd19,
        OP_AND  = 5'd20,
        OP_OR   = 5'd21,
        OP_XOR  = 5'd22
    } t_op;

    // Control and side results that travel alongside the divider.
    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic              is_mod;
        logic              neg_q;
        logic              neg_r;
        logic              b_zero;
        logic              ok;
        logic [WORD_W-1:0] res;
    } t_ctl;

    // Divider working set: partial remainder, dividend shifting out while
    // quotient bits shift in, and the divisor magnitude.
    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] dvsr;
    } t_dvw;

endpackage

@@ design/swa_simple.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swa_simple
// Combinational operations: logic, compares, shifts, add, subtract and the
// truncated multiply. Divide and modulo are only flagged here.
// ----------------------------------------------------------------------------
module swa_simple (
    input  logic [swa_pkg::OP_W-1:0]   i_op,
    input  logic [swa_pkg::WORD_W-1:0] i_a,
    input  logic [swa_pkg::WORD_W-1:0] i_b,
    output logic [swa_pkg::WORD_W-1:0] o_res,
    output logic                       o_ok,
    output logic                       o_is_div,
    output logic                       o_is_mod
);

    logic                       w_big_shift;
    logic                       w_slt;
    logic                       w_seq;
    logic [2*swa_pkg::WORD_W-1:0] w_prod;

    assign w_big_shift = |i_b[swa_pkg::WORD_W-1:4];
    assign w_seq       = (i_a == i_b);
    assign w_slt       = ($signed(i_a) < $signed(i_b));
    assign w_prod      = i_a * i_b;

    always_comb begin
        o_res    = '0;
        o_ok     = 1'b1;
        o_is_div = 1'b0;
        o_is_mod = 1'b0;
        unique case (swa_pkg::t_op'(i_op))
            swa_pkg::OP_BNOT: o_res = ~i_a;
            swa_pkg::OP_NOT:  o_res = swa_pkg::WORD_W'(i_a == '0);
            swa_pkg::OP_NEG:  o_res = '0 - i_a;
            swa_pkg::OP_EQ:   o_res = swa_pkg::WORD_W'(w_seq);
            swa_pkg::OP_NE:   o_res = swa_pkg::WORD_W'(!w_seq);
            swa_pkg::OP_UGE:  o_res = swa_pkg::WORD_W'(i_a >= i_b);
            swa_pkg::OP_GE:   o_res = swa_pkg::WORD_W'(!w_slt);
            swa_pkg::OP_UGT:  o_res = swa_pkg::WORD_W'(i_a > i_b);
            swa_pkg::OP_SHR:  o_res = w_big_shift ? '0 : (i_a >> i_b[3:0]);
            swa_pkg::OP_GT:   o_res = swa_pkg::WORD_W'(!w_slt && !w_seq);
            swa_pkg::OP_ULE:  o_res = swa_pkg::WORD_W'(i_a <= i_b);
            swa_pkg::OP_LE:   o_res = swa_pkg::WORD_W'(w_slt || w_seq);
            swa_pkg::OP_ULT:  o_res = swa_pkg::WORD_W'(i_a < i_b);
            swa_pkg::OP_SHL:  o_res = w_big_shift ? '0 : (i_a << i_b[3:0]);
            swa_pkg::OP_LT:   o_res = swa_pkg::WORD_W'(w_slt);
            swa_pkg::OP_ADD:  o_res = i_a + i_b;
            swa_pkg::OP_SUB:  o_res = i_a - i_b;
            swa_pkg::OP_MUL:  o_res = w_prod[swa_pkg::WORD_W-1:0];
            swa_pkg::OP_DIV:  o_is_div = 1'b1;
            swa_pkg::OP_MOD:  o_is_mod = 1'b1;
            swa_pkg::OP_AND:  o_res = i_a & i_b;
            swa_pkg::OP_OR:   o_res = i_a | i_b;
            swa_pkg::OP_XOR:  o_res = i_a ^ i_b;
            default:          o_ok = 1'b0;
        endcase
    end

endmodule

@@ design/swa_div_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swa_div_stage
// One register stage of the unsigned restoring divider, computing four
// quotient bits and carrying the item's control record along.
// ----------------------------------------------------------------------------
module swa_div_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  swa_pkg::t_ctl i_ctl,
    input  swa_pkg::t_dvw i_dv,
    output swa_pkg::t_ctl o_ctl,
    output swa_pkg::t_dvw o_dv
);

    swa_pkg::t_ctl r_ctl;
    swa_pkg::t_dvw r_dv;
    swa_pkg::t_dvw n_dv;

    always_comb begin
        logic [swa_pkg::WORD_W:0] v_t;
        n_dv = i_dv;
        for (int k = 0; k < swa_pkg::DIV_STEPS; k++) begin
            v_t      = {n_dv.rem, n_dv.quo[swa_pkg::WORD_W-1]};
            n_dv.quo = {n_dv.quo[swa_pkg::WORD_W-2:0], 1'b0};
            if (v_t >= {1'b0, n_dv.dvsr}) begin
                v_t         = v_t - {1'b0, n_dv.dvsr};
                n_dv.quo[0] = 1'b1;
            end
            n_dv.rem = v_t[swa_pkg::WORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv <= n_dv;
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    assign o_ctl = r_ctl;
    assign o_dv  = r_dv;

endmodule

@@ design/signed_word_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_word_alu
// 16-bit ALU pipeline: input register, decode and combinational operations,
// four divider stages, result register.
// ----------------------------------------------------------------------------
// The result strobe passes the input, decode, divider and result registers,
// the same path for every operation; the four divider stages set the depth.
// Throughput: one item per cycle; busy stays low since nothing can stall.
// Reset (synchronous, active low) clears every stage valid bit and the result
// strobe, so no result strobe follows reset until a new item is accepted.
module signed_word_alu (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [swa_pkg::OP_W-1:0]   i_action,
    input  logic [swa_pkg::WORD_W-1:0] i_operand_a,
    input  logic [swa_pkg::WORD_W-1:0] i_operand_b,
    output logic                       o_done,
    output logic [swa_pkg::WORD_W-1:0] o_value,
    output logic                       o_valid_res
);

    localparam int W = swa_pkg::WORD_W;

    // Stage A: input register.
    logic                   r_a_valid;
    logic [swa_pkg::OP_W-1:0] r_a_action;
    logic [W-1:0]           r_a_a;
    logic [W-1:0]           r_a_b;

    // Stage B: decoded item and divider setup.
    swa_pkg::t_ctl r_b_ctl;
    swa_pkg::t_ctl n_b_ctl;
    swa_pkg::t_dvw r_b_dv;
    swa_pkg::t_dvw n_b_dv;

    swa_pkg::t_ctl w_ctl [swa_pkg::DIV_STAGES+1];
    swa_pkg::t_dvw w_dv  [swa_pkg::DIV_STAGES+1];

    logic [W-1:0] w_res;
    logic         w_ok;
    logic         w_is_div;
    logic         w_is_mod;

    logic         r_done;
    logic [W-1:0] r_value;
    logic         r_valid_res;
    logic [W-1:0] n_value;
    logic         n_valid_res;
    logic [W-1:0] w_q_fix;
    logic [W-1:0] w_r_fix;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        r_a_action <= i_action;
        r_a_a      <= i_operand_a;
        r_a_b      <= i_operand_b;
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= start && !busy;
        end
    end

    swa_simple u_simple (
        .i_op     (r_a_action),
        .i_a      (r_a_a),
        .i_b      (r_a_b),
        .o_res    (w_res),
        .o_ok     (w_ok),
        .o_is_div (w_is_div),
        .o_is_mod (w_is_mod)
    );

    always_comb begin
        n_b_ctl.valid  = r_a_valid;
        n_b_ctl.is_div = w_is_div;
        n_b_ctl.is_mod = w_is_mod;
        n_b_ctl.neg_q  = r_a_a[W-1] ^ r_a_b[W-1];
        n_b_ctl.neg_r  = r_a_a[W-1];
        n_b_ctl.b_zero = (r_a_b == '0);
        n_b_ctl.ok     = w_ok;
        n_b_ctl.res    = w_res;
        n_b_dv.rem     = '0;
        n_b_dv.quo     = r_a_a[W-1] ? ('0 - r_a_a) : r_a_a;
        n_b_dv.dvsr    = r_a_b[W-1] ? ('0 - r_a_b) : r_a_b;
    end

    always_ff @(posedge i_clk) begin
        r_b_dv <= n_b_dv;
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else begin
            r_b_ctl <= n_b_ctl;
        end
    end

    assign w_ctl[0] = r_b_ctl;
    assign w_dv[0]  = r_b_dv;

    for (genvar g = 0; g < swa_pkg::DIV_STAGES; g++) begin : g_div
        swa_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_dv    (w_dv[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_dv    (w_dv[g+1])
        );
    end

    // Quotient sign follows the operand signs, remainder sign the dividend.
    assign w_q_fix = w_ctl[swa_pkg::DIV_STAGES].neg_q ?
                     ('0 - w_dv[swa_pkg::DIV_STAGES].quo) : w_dv[swa_pkg::DIV_STAGES].quo;
    assign w_r_fix = w_ctl[swa_pkg::DIV_STAGES].neg_r ?
                     ('0 - w_dv[swa_pkg::DIV_STAGES].rem) : w_dv[swa_pkg::DIV_STAGES].rem;

    always_comb begin
        n_valid_res = w_ctl[swa_pkg::DIV_STAGES].ok;
        if (!w_ctl[swa_pkg::DIV_STAGES].ok || w_ctl[swa_pkg::DIV_STAGES].b_zero &&
            (w_ctl[swa_pkg::DIV_STAGES].is_div || w_ctl[swa_pkg::DIV_STAGES].is_mod)) begin
            n_value = '0;
        end else if (w_ctl[swa_pkg::DIV_STAGES].is_div) begin
            n_value = w_q_fix;
        end else if (w_ctl[swa_pkg::DIV_STAGES].is_mod) begin
            n_value = w_r_fix;
        end else begin
            n_value = w_ctl[swa_pkg::DIV_STAGES].res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value     <= n_value;
        r_valid_res <= n_valid_res;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_ctl[swa_pkg::DIV_STAGES].valid;
        end
    end

    assign o_done      = r_done;
    assign o_value     = r_value;
    assign o_valid_res = r_valid_res;

    // A result only ever follows an item accepted a fixed depth earlier.
    a_done_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 7))
        else $error("result strobe without an accepted item");

    a_done_from_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_b_ctl.valid, 5))
        else $error("result strobe not matched by the decode stage");

    a_bad_op_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_valid_res |-> o_value == '0)
        else $error("unsupported operation gave a nonzero value");

    a_bad_op_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_valid_res |-> $past(i_action, 7) > swa_pkg::OP_W'(swa_pkg::OP_XOR))
        else $error("supported operation flagged as unsupported");

endmodule
